### sv/dq_pkg.sv
`default_nettype none

package dq_pkg;

    localparam int WORD_W   = 32;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 2;

    // request opcodes
    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_REAR  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_LIST       = 3'd4
    } opcode_e;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_e;

    // operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_PUSH_REAR,
        CELL_PUSH_FRONT,
        CELL_POP_FRONT,
        CELL_POP_REAR,
        CELL_ROTATE
    } cell_op_e;

    typedef struct packed {
        cell_op_e                   op;
        logic signed [WORD_W-1:0]   word;
    } cell_cmd_t;

endpackage

`default_nettype wire

### sv/dq_req_if.sv
`default_nettype none

interface dq_req_if;
    import dq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [WORD_W-1:0]   value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

### sv/dq_rsp_if.sv
`default_nettype none

interface dq_rsp_if;
    import dq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic signed [WORD_W-1:0]   value_out;
    logic                       last;

    modport source (output valid, output status, output value_out, output last, input ready);
    modport sink   (input valid, input status, input value_out, input last, output ready);
endinterface

`default_nettype wire

### sv/dq_cell.sv
`default_nettype none

module dq_cell (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire dq_pkg::cell_cmd_t                  cmd,
    input  wire logic signed [dq_pkg::WORD_W-1:0]   left_data,
    input  wire logic                               left_occ,
    input  wire logic signed [dq_pkg::WORD_W-1:0]   right_data,
    input  wire logic                               right_occ,
    input  wire logic signed [dq_pkg::WORD_W-1:0]   head_data,
    output logic signed [dq_pkg::WORD_W-1:0]        data,
    output logic                                    occ,
    output logic signed [dq_pkg::WORD_W-1:0]        rear_word
);
    import dq_pkg::*;

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;
    logic                     occ_reg;
    logic                     occ_next;
    logic                     is_rear;

    // this cell holds the rear entry when its right neighbor is empty
    assign is_rear = occ_reg && !right_occ;

    // next contents from the broadcast operation and the two neighbors
    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        unique case (cmd.op)
            CELL_NOP:
            begin
                data_next = data_reg;
            end
            CELL_PUSH_REAR:
            begin
                if (!occ_reg && left_occ)
                begin
                    data_next = cmd.word;
                    occ_next  = 1'b1;
                end
            end
            CELL_PUSH_FRONT:
            begin
                data_next = left_data;
                occ_next  = left_occ;
            end
            CELL_POP_FRONT:
            begin
                data_next = right_data;
                occ_next  = right_occ;
            end
            CELL_POP_REAR:
            begin
                occ_next = occ_reg && right_occ;
            end
            CELL_ROTATE:
            begin
                data_next = is_rear ? head_data : right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // stored word
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign occ       = occ_reg;
    assign rear_word = is_rear ? data_reg : '0;

endmodule

`default_nettype wire

### sv/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words.
// Requests arrive on req (opcode, value) and responses leave on rsp
// (status, value_out, last), both valid/ready channels; a transaction
// moves at a clock edge with valid and ready high.
// Storage is a row of DEPTH cells; cell 0 holds the front entry and each
// cell shifts its word to a neighbor when an entry enters or leaves the
// front. Push front, push rear, pop front and pop rear each give one
// response with last set, registered in the cycle after acceptance.
// A list request rotates the row one cell per cycle while the receiver
// takes responses, emitting the front word each time: N entries give N
// responses, with last on the rear entry; the row is back in order at
// the end. Requests are held off while a list is running.
// Pops and lists on an empty queue answer status empty; a push on a
// full queue is dropped and answers status full. Opcodes 5..7 are taken
// and give no response.
// The response register frees when rsp is taken; while the receiver
// stalls, no new request is accepted and a running list pauses.
// Reset empties the queue at once; stored words need no clearing.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dq_req_if.sink      req,
    dq_rsp_if.source    rsp
);
    import dq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // cell row wiring
    logic signed [WORD_W-1:0] cell_data [DEPTH];
    logic signed [WORD_W-1:0] cell_rear [DEPTH];
    logic [DEPTH-1:0]         cell_occ;
    cell_cmd_t                cmd;

    // control and response registers
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         remain_reg, remain_next;
    logic                     listing_reg, listing_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic signed [WORD_W-1:0] value_out_reg, value_out_next;
    logic                     last_reg, last_next;

    logic                     slot_free;
    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     emit;
    logic signed [WORD_W-1:0] rear_data;

    // the chain of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] l_data;
        logic signed [WORD_W-1:0] r_data;
        logic                     l_occ;
        logic                     r_occ;

        if (i == 0)
        begin : g_first
            assign l_data = cmd.word;
            assign l_occ  = 1'b1;
        end
        else
        begin : g_mid_l
            assign l_data = cell_data[i-1];
            assign l_occ  = cell_occ[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign r_data = '0;
            assign r_occ  = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_data = cell_data[i+1];
            assign r_occ  = cell_occ[i+1];
        end

        dq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .left_data  (l_data),
            .left_occ   (l_occ),
            .right_data (r_data),
            .right_occ  (r_occ),
            .head_data  (cell_data[0]),
            .data       (cell_data[i]),
            .occ        (cell_occ[i]),
            .rear_word  (cell_rear[i])
        );
    end

    // rear word: only one cell drives a nonzero value
    always_comb
    begin
        rear_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_data = rear_data | cell_rear[i];
        end
    end

    assign full      = cell_occ[DEPTH-1];
    assign empty     = !cell_occ[0];
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = !listing_reg && slot_free;
    assign accept    = req.valid && req.ready;

    // request decode, list sequencing and response selection
    always_comb
    begin
        cmd.op         = CELL_NOP;
        cmd.word       = req.value;
        count_next     = count_reg;
        remain_next    = remain_reg;
        listing_next   = listing_reg;
        emit           = 1'b0;
        status_next    = ST_OK;
        value_out_next = '0;
        last_next      = 1'b1;

        priority if (listing_reg)
        begin
            if (slot_free)
            begin
                cmd.op         = CELL_ROTATE;
                emit           = 1'b1;
                value_out_next = cell_data[0];
                last_next      = (remain_reg == CNT_W'(1));
                remain_next    = remain_reg - CNT_W'(1);
                if (remain_reg == CNT_W'(1))
                begin
                    listing_next = 1'b0;
                end
            end
        end
        else if (accept)
        begin
            unique case (req.opcode)
                OP_PUSH_REAR, OP_PUSH_FRONT:
                begin
                    emit = 1'b1;
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.op     = (req.opcode == OP_PUSH_REAR) ? CELL_PUSH_REAR
                                                                  : CELL_PUSH_FRONT;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_POP_FRONT, OP_POP_REAR:
                begin
                    emit = 1'b1;
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        if (req.opcode == OP_POP_FRONT)
                        begin
                            cmd.op         = CELL_POP_FRONT;
                            value_out_next = cell_data[0];
                        end
                        else
                        begin
                            cmd.op         = CELL_POP_REAR;
                            value_out_next = rear_data;
                        end
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_LIST:
                begin
                    if (empty)
                    begin
                        emit        = 1'b1;
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        listing_next = 1'b1;
                        remain_next  = count_reg;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
        else
        begin
            emit = 1'b0;
        end
    end

    // response valid flag
    always_comb
    begin
        priority if (emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            remain_reg    <= '0;
            listing_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            listing_reg   <= listing_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg    <= status_next;
            value_out_reg <= value_out_next;
            last_reg      <= last_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.value_out = value_out_reg;
    assign rsp.last      = last_reg;

    // count agrees with the occupancy of the row
    a_count_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cell_occ[0] == (count_reg != '0))
        else $error("count disagrees with front cell occupancy");

    a_count_full: assert property (@(posedge clk) disable iff (!rst_n)
        cell_occ[DEPTH-1] == (count_reg == CNT_W'(DEPTH)))
        else $error("count disagrees with rear cell occupancy");

    // occupied cells form one run starting at the front
    a_occ_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_occ + DEPTH'(1)) & cell_occ) == '0)
        else $error("gap in the occupied cells");

    // a running list always has entries left to send
    a_list_remain: assert property (@(posedge clk) disable iff (!rst_n)
        listing_reg |-> (remain_reg != '0 && remain_reg <= count_reg))
        else $error("list counter out of range");

    // the final list response ends the list
    a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
        (listing_reg && slot_free && remain_reg == CNT_W'(1)) |=>
            (!listing_reg && rsp.valid && rsp.last))
        else $error("list did not finish with a last response");

endmodule

`default_nettype wire

### verif/double_ended_queue_test.sv
`timescale 1ns / 1ps

module double_ended_queue_test;
    import dq_pkg::*;

    localparam int QDEPTH      = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 40;

    // opcodes the block takes and ignores
    localparam logic [OPCODE_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_RSVD_7 = 3'd7;

    typedef struct packed {
        status_e            status;
        logic [WORD_W-1:0]  word;
        logic               last;
    } dq_result_t;

    logic clk;
    logic rst_n;

    dq_req_if req_ch ();
    dq_rsp_if rsp_ch ();

    double_ended_queue #(.DEPTH(QDEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow copy of the queue contents
    logic [WORD_W-1:0]  shadow_words [QDEPTH];
    logic [3:0]         shadow_head;
    logic [4:0]         shadow_count;
    dq_result_t         pending_results [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned requests_taken = 0;
    int unsigned results_seen   = 0;
    int unsigned full_answers   = 0;
    int unsigned empty_answers  = 0;
    int unsigned list_answers   = 0;

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending_results.size());
            $display("** double_ended_queue: FAILED **");
            $finish;
        end
    end

    // receiver backpressure
    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
    endtask

    function automatic void queue_result(status_e st, logic [WORD_W-1:0] w, logic l);
        dq_result_t r;
        r.status = st;
        r.word   = w;
        r.last   = l;
        pending_results.push_back(r);
    endfunction

    // expected results of one accepted request; updates the shadow queue
    function automatic void predict_request(logic [OPCODE_W-1:0] op,
                                            logic [WORD_W-1:0] val);
        logic [3:0] pos;
        case (op)
            OP_PUSH_REAR:
            begin
                if (shadow_count == QDEPTH)
                    queue_result(ST_FULL, '0, 1'b1);
                else
                begin
                    pos = shadow_head + shadow_count[3:0];
                    shadow_words[pos] = val;
                    shadow_count++;
                    queue_result(ST_OK, '0, 1'b1);
                end
            end
            OP_PUSH_FRONT:
            begin
                if (shadow_count == QDEPTH)
                    queue_result(ST_FULL, '0, 1'b1);
                else
                begin
                    shadow_head = shadow_head - 4'd1;
                    shadow_words[shadow_head] = val;
                    shadow_count++;
                    queue_result(ST_OK, '0, 1'b1);
                end
            end
            OP_POP_FRONT:
            begin
                if (shadow_count == 0)
                    queue_result(ST_EMPTY, '0, 1'b1);
                else
                begin
                    queue_result(ST_OK, shadow_words[shadow_head], 1'b1);
                    shadow_head = shadow_head + 4'd1;
                    shadow_count--;
                end
            end
            OP_POP_REAR:
            begin
                if (shadow_count == 0)
                    queue_result(ST_EMPTY, '0, 1'b1);
                else
                begin
                    pos = shadow_head + 4'(shadow_count - 5'd1);
                    queue_result(ST_OK, shadow_words[pos], 1'b1);
                    shadow_count--;
                end
            end
            OP_LIST:
            begin
                if (shadow_count == 0)
                    queue_result(ST_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < shadow_count; i++)
                    begin
                        pos = shadow_head + 4'(i);
                        queue_result(ST_OK, shadow_words[pos], (i + 1 == shadow_count));
                    end
            end
            default:
            begin
                // reserved opcode: nothing happens
            end
        endcase
    endfunction

    // response check, then prediction of the transaction taken at this edge
    always @(posedge clk)
    begin
        dq_result_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (rsp_ch.status == ST_FULL)
                    full_answers++;
                if (rsp_ch.status == ST_EMPTY)
                    empty_answers++;
                if (pending_results.size() == 0)
                    report_mismatch("unexpected response, value_out", rsp_ch.value_out, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
                    if (rsp_ch.value_out !== want.word)
                        report_mismatch("value_out", rsp_ch.value_out, want.word);
                    if (rsp_ch.last !== want.last)
                        report_mismatch("last", 32'(rsp_ch.last), 32'(want.last));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                requests_taken++;
                if (req_ch.opcode == OP_LIST && shadow_count > 1)
                    list_answers++;
                predict_request(req_ch.opcode, req_ch.value);
            end
        end
    end

    // one request transaction; called and returns at a falling edge
    task automatic send_request(logic [OPCODE_W-1:0] op, logic [WORD_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.value  <= val;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold off until every pending result is back
    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(11))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // pops and list on an empty queue, reserved opcodes
    task automatic test_empty_queue();
        send_request(OP_POP_FRONT, 32'h1234_5678);
        send_request(OP_POP_REAR, '1);
        send_request(OP_LIST, '0);
        send_request(OP_RSVD_5, 32'h7fff_ffff);
        send_request(OP_RSVD_7, 32'h8000_0000);
    endtask

    // fill from both ends with extreme and random words, overflow, list, pop both ends
    task automatic test_fill_and_overflow();
        logic [WORD_W-1:0] w;
        for (int i = 0; i < QDEPTH; i++)
        begin
            case (i % 4)
                0:       w = 32'h7fff_ffff;
                1:       w = 32'h8000_0000;
                2:       w = '0;
                default: w = '1;
            endcase
            if (i % 4 == 3)
                w = $urandom;
            send_request((i % 2) ? OP_PUSH_FRONT : OP_PUSH_REAR, w);
        end
        send_request(OP_PUSH_REAR, 32'hdead_beef);
        send_request(OP_PUSH_FRONT, 32'h0bad_f00d);
        send_request(OP_LIST, '0);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_POP_REAR, '0);
    endtask

    // random traffic that swings between filling and draining
    task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                       int unsigned n_items);
        logic                   filling;
        logic                   grow;
        logic [OPCODE_W-1:0]    op;
        int unsigned            r;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        filling = 1'($urandom_range(1));
        for (int n = 0; n < n_items; n++)
        begin
            if (shadow_count == QDEPTH)
                filling = 1'b0;
            else if (shadow_count == 0)
                filling = 1'b1;
            else if ($urandom_range(99) < 6)
                filling = ~filling;
            r = $urandom_range(99);
            grow = (r < 80) ? filling : ~filling;
            if (r < 3)
            begin
                case ($urandom_range(2))
                    0:       op = OP_RSVD_5;
                    1:       op = OP_RSVD_6;
                    default: op = OP_RSVD_7;
                endcase
            end
            else if (r < 15)
                op = OP_LIST;
            else if (grow)
                op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
            else
                op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
            send_request(op, pick_word());
        end
        wait_until_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.opcode = OP_PUSH_REAR;
        req_ch.value  = '0;
        shadow_head   = '0;
        shadow_count  = '0;

        // single reset at start of run
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_queue();
        test_fill_and_overflow();
        wait_until_drained();

        test_random_traffic(0, 0, 96);
        test_random_traffic(46, 0, 96);
        test_random_traffic(0, 46, 96);
        test_random_traffic(28, 28, 96);

        // final drain and settle
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);

        $display("covered %0d requests and %0d responses over %0d cycles",
                 requests_taken, results_seen, cycle_count);
        $display("answers: %0d full, %0d empty, %0d multi-entry lists; %0d mismatches",
                 full_answers, empty_answers, list_answers, error_count);
        if (error_count == 0)
            $display("** double_ended_queue: PASSED **");
        else
            $display("** double_ended_queue: FAILED **");
        $finish;
    end

endmodule
